### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// An antecedent that implies a consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/core/cleb_pkg.sv
package cleb_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned PosW   = 7;

  localparam logic [CharW-1:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [CharW-1:0] CHAR_SPACE      = 8'h20;

  typedef enum logic [2:0] {
    MODE_ADD   = 3'd0,
    MODE_ERASE = 3'd1,
    MODE_LEFT  = 3'd2,
    MODE_RIGHT = 3'd3,
    MODE_READ  = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_WR,
    ST_INS_PUT,
    ST_ERA_RD,
    ST_ERA_WR,
    ST_ERA_FIN,
    ST_RD_WAIT
  } state_e;

  typedef struct packed {
    logic [2:0]       mode;
    logic [CharW-1:0] char_code;
    logic [IdxW-1:0]  read_index;
  } item_t;

  typedef struct packed {
    logic [CharW-1:0] read_char;
    logic             read_valid;
    logic             applied;
    logic [PosW-1:0]  cursor_now;
    logic [PosW-1:0]  length_now;
  } result_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

### rtl/core/cleb_store.sv
module cleb_store
  import cleb_pkg::*;
#(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  mem_ctl_t         ctl_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [CharW-1:0] wdata_i,
  output logic [CharW-1:0] rdata_o
);

  logic [CharW-1:0] mem_q [Depth];
  logic [CharW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/cleb_ctrl.sv
`include "assert_macros.svh"

module cleb_ctrl
  import cleb_pkg::*;
#(
  parameter int unsigned Capacity = 64,
  parameter int unsigned AddrW    = 6,
  parameter int unsigned CountW   = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  item_t            item_i,
  output logic             busy_o,
  output logic             done_o,
  output result_t          result_o,
  output mem_ctl_t         mem_ctl_o,
  output logic [AddrW-1:0] mem_addr_o,
  output logic [CharW-1:0] mem_wdata_o,
  input  logic [CharW-1:0] mem_rdata_i
);

  localparam int unsigned CmpW = (CountW > IdxW) ? CountW + 1 : IdxW + 1;

  state_e              state_q, state_d;
  logic [CountW-1:0]   cur_q, cur_d;
  logic [CountW-1:0]   len_q, len_d;
  logic [CountW-1:0]   ptr_q, ptr_d;
  logic [CharW-1:0]    ch_q, ch_d;
  result_t             res_q, res_d;
  logic                res_vld_q, res_vld_d;

  logic                accept;
  logic                add_ok, erase_ok, left_ok, right_ok, read_ok;
  logic [CountW-1:0]   ptr_dec, ptr_inc;
  logic [CharW-1:0]    ch_mapped;

  assign accept    = start_i && (state_q == ST_IDLE);
  assign add_ok    = len_q < CountW'(Capacity);
  assign erase_ok  = (cur_q != '0) && (len_q != '0);
  assign left_ok   = (len_q != '0) && (cur_q != '0);
  assign right_ok  = cur_q < len_q;
  assign read_ok   = CmpW'(item_i.read_index) < CmpW'(len_q);
  assign ptr_dec   = ptr_q - 1'b1;
  assign ptr_inc   = ptr_q + 1'b1;
  assign ch_mapped = (item_i.char_code == CHAR_UNDERSCORE) ? CHAR_SPACE : item_i.char_code;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          priority if (item_i.mode == MODE_ADD && add_ok) begin
            state_d = (len_q == cur_q) ? ST_INS_PUT : ST_INS_RD;
          end else if (item_i.mode == MODE_ERASE && erase_ok) begin
            state_d = (cur_q == len_q) ? ST_ERA_FIN : ST_ERA_RD;
          end else if (item_i.mode == MODE_READ && read_ok) begin
            state_d = ST_RD_WAIT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_INS_RD:  state_d = ST_INS_WR;
      ST_INS_WR:  state_d = (ptr_dec == cur_q) ? ST_INS_PUT : ST_INS_RD;
      ST_INS_PUT: state_d = ST_IDLE;
      ST_ERA_RD:  state_d = ST_ERA_WR;
      ST_ERA_WR:  state_d = (ptr_inc == len_q) ? ST_ERA_FIN : ST_ERA_RD;
      ST_ERA_FIN: state_d = ST_IDLE;
      ST_RD_WAIT: state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cur_d       = cur_q;
    len_d       = len_q;
    ptr_d       = ptr_q;
    ch_d        = ch_q;
    res_d       = res_q;
    res_vld_d   = 1'b0;
    mem_ctl_o   = '0;
    mem_addr_o  = '0;
    mem_wdata_o = mem_rdata_i;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d            = '0;
          res_d.cursor_now = PosW'(cur_q);
          res_d.length_now = PosW'(len_q);
          unique case (item_i.mode)
            MODE_ADD: begin
              ch_d  = ch_mapped;
              ptr_d = len_q;
              res_vld_d = !add_ok;
            end
            MODE_ERASE: begin
              ptr_d = cur_q;
              res_vld_d = !erase_ok;
            end
            MODE_LEFT: begin
              res_vld_d = 1'b1;
              if (left_ok) begin
                cur_d            = cur_q - 1'b1;
                res_d.applied    = 1'b1;
                res_d.cursor_now = PosW'(cur_d);
              end
            end
            MODE_RIGHT: begin
              res_vld_d = 1'b1;
              if (right_ok) begin
                cur_d            = cur_q + 1'b1;
                res_d.applied    = 1'b1;
                res_d.cursor_now = PosW'(cur_d);
              end
            end
            MODE_READ: begin
              res_vld_d    = !read_ok;
              mem_ctl_o.re = read_ok;
              mem_addr_o   = AddrW'(item_i.read_index);
            end
            default: res_vld_d = 1'b1;
          endcase
        end
      end
      ST_INS_RD: begin
        mem_ctl_o.re = 1'b1;
        mem_addr_o   = AddrW'(ptr_dec);
      end
      ST_INS_WR: begin
        mem_ctl_o.we = 1'b1;
        mem_addr_o   = AddrW'(ptr_q);
        ptr_d        = ptr_dec;
      end
      ST_INS_PUT: begin
        mem_ctl_o.we     = 1'b1;
        mem_addr_o       = AddrW'(cur_q);
        mem_wdata_o      = ch_q;
        cur_d            = cur_q + 1'b1;
        len_d            = len_q + 1'b1;
        res_vld_d        = 1'b1;
        res_d.applied    = 1'b1;
        res_d.cursor_now = PosW'(cur_d);
        res_d.length_now = PosW'(len_d);
      end
      ST_ERA_RD: begin
        mem_ctl_o.re = 1'b1;
        mem_addr_o   = AddrW'(ptr_q);
      end
      ST_ERA_WR: begin
        mem_ctl_o.we = 1'b1;
        mem_addr_o   = AddrW'(ptr_dec);
        ptr_d        = ptr_inc;
      end
      ST_ERA_FIN: begin
        cur_d            = cur_q - 1'b1;
        len_d            = len_q - 1'b1;
        res_vld_d        = 1'b1;
        res_d.applied    = 1'b1;
        res_d.cursor_now = PosW'(cur_d);
        res_d.length_now = PosW'(len_d);
      end
      ST_RD_WAIT: begin
        res_vld_d        = 1'b1;
        res_d.read_valid = 1'b1;
        res_d.read_char  = mem_rdata_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cur_q     <= '0;
      len_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_q     <= cur_d;
      len_q     <= len_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    ch_q  <= ch_d;
    res_q <= res_d;
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign done_o   = res_vld_q;
  assign result_o = res_q;

  `ASSERT_ALWAYS(a_cur_le_len, clk_i, rst_ni, cur_q <= len_q, "cursor beyond length")
  `ASSERT_ALWAYS(a_len_le_cap, clk_i, rst_ni, len_q <= CountW'(Capacity), "length beyond capacity")
  `ASSERT_ALWAYS(a_mem_one_op, clk_i, rst_ni, !(mem_ctl_o.we && mem_ctl_o.re), "read and write together")
  `ASSERT_IMPL(a_done_idle, clk_i, rst_ni, res_vld_q, state_q == ST_IDLE, "result while still busy")

endmodule

### rtl/core/cursor_line_edit_buffer_top.sv
// Moves, erroneous or no-op items give the result in the cycle after the transfer;
// a read waits in ST_RD_WAIT for the registered memory read; add and erase shift each
// character from the cursor on, with one read and one write on the single-port text
// memory, then finish. Items are taken only while idle. The receiver cannot stall results.
// Reset clears cursor, length and control state; the text memory is not cleared.
module cursor_line_edit_buffer_top
  import cleb_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  item_t   item_i,
  output logic    busy,
  output logic    done_o,
  output result_t result_o
);

  localparam int unsigned AddrW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CountW = $clog2(CAPACITY + 1);

  mem_ctl_t         mem_ctl;
  logic [AddrW-1:0] mem_addr;
  logic [CharW-1:0] mem_wdata;
  logic [CharW-1:0] mem_rdata;

  cleb_ctrl #(
    .Capacity (CAPACITY),
    .AddrW    (AddrW),
    .CountW   (CountW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .item_i      (item_i),
    .busy_o      (busy),
    .done_o      (done_o),
    .result_o    (result_o),
    .mem_ctl_o   (mem_ctl),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  cleb_store #(
    .Depth (CAPACITY),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule
